>>> sv/lidar_point_stream_filter_assert.svh
// assertion macros for the lidar point stream filter
`ifndef LIDAR_POINT_STREAM_FILTER_ASSERT_SVH
`define LIDAR_POINT_STREAM_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LPSF_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lpsf assertion failed");

// next-cycle implication
`define LPSF_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lpsf assertion failed");

`else

`define LPSF_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define LPSF_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

>>> sv/lpsf_pkg.sv
// shared types and constants of the lidar point stream filter
package lpsf_pkg;

    localparam int CoordWidth  = 32;
    localparam int SquareWidth = 2 * CoordWidth;
    localparam int CfgWidth    = 40;
    localparam int CfgIdxWidth = 2;

    localparam logic [CfgIdxWidth-1:0] REG_SCAN_LINE_COUNT  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_DECIMATION_RATIO = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_BLIND_RADIUS_SQ  = 2'd2;

    localparam logic [7:0]  SCAN_LINE_COUNT_RESET  = 8'd6;
    localparam logic [7:0]  DECIMATION_RATIO_RESET = 8'd1;
    localparam logic [39:0] BLIND_RADIUS_SQ_RESET  = 40'd42949673;

    localparam logic [7:0] ECHO_MASK   = 8'h30;
    localparam logic [7:0] ECHO_FIRST  = 8'h00;
    localparam logic [7:0] ECHO_SECOND = 8'h10;

    typedef struct packed {
        logic                         frame_start;
        logic signed [CoordWidth-1:0] pos_x;
        logic signed [CoordWidth-1:0] pos_y;
        logic signed [CoordWidth-1:0] pos_z;
        logic [7:0]                   reflectivity;
        logic [7:0]                   tag_bits;
        logic [7:0]                   scan_line;
        logic [31:0]                  time_offset_ns;
    } point_in_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] out_x;
        logic signed [CoordWidth-1:0] out_y;
        logic signed [CoordWidth-1:0] out_z;
        logic [7:0]                   out_intensity;
        logic [31:0]                  out_time_ns;
    } point_out_t;

    typedef struct packed {
        logic [7:0]          scan_line_count;
        logic [7:0]          decimation_ratio;
        logic [CfgWidth-1:0] blind_radius_sq;
    } cfg_t;

    typedef struct packed {
        point_in_t              pt;
        logic [SquareWidth-1:0] sq_x;
        logic [SquareWidth-1:0] sq_y;
    } stage_t;

endpackage

>>> sv/lidar_point_stream_filter.sv
// top level of the lidar point stream filter
//
//  channel   | beat type              | handshake
//  ----------+------------------------+--------------------------------
//  point     | lpsf_pkg::point_in_t   | point_valid / point_stall
//  result    | lpsf_pkg::point_out_t  | result_valid / result_stall
//  cfg       | 40 bit data, 2 bit idx | cfg_wr_en, no wait
//
// one point per cycle sustained while result_stall stays low; a point enters the input register
// when it is accepted and then passes through the squares register to the result register
// the 32x32 squaring is cut off by its own register ahead of the decision stage
// reset clears config to defaults, the point history, the decimation phase and all valids
// result_stall backs up through both internal stages to point_stall in the same cycle
// points that produce no result are dropped without a result beat
`include "lidar_point_stream_filter_assert.svh"

module lidar_point_stream_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  lpsf_pkg::point_in_t                 point_data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output lpsf_pkg::point_out_t                result_data,
    input  logic                                cfg_wr_en,
    input  logic [lpsf_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [lpsf_pkg::CfgWidth-1:0]       cfg_data
);

    lpsf_pkg::cfg_t       cfg_reg, cfg_next;
    lpsf_pkg::point_in_t  s1_reg;
    lpsf_pkg::stage_t     s2_reg, s2_next;
    lpsf_pkg::point_out_t result_reg;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic result_valid_reg, result_valid_next;
    logic out_free;
    logic s2_load;
    logic s1_load;
    logic point_accept;
    logic emit;
    logic [lpsf_pkg::CoordWidth-1:0] mag_x;
    logic [lpsf_pkg::CoordWidth-1:0] mag_y;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lpsf_pkg::REG_SCAN_LINE_COUNT:  cfg_next.scan_line_count  = cfg_data[7:0];
                lpsf_pkg::REG_DECIMATION_RATIO: cfg_next.decimation_ratio = cfg_data[7:0];
                lpsf_pkg::REG_BLIND_RADIUS_SQ:  cfg_next.blind_radius_sq  = cfg_data;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_free     = !result_valid_reg || !result_stall;
        s2_load      = !s2_valid_reg || out_free;
        s1_load      = !s1_valid_reg || s2_load;
        point_accept = point_valid && s1_load;

        s1_valid_next     = s1_load ? point_valid : s1_valid_reg;
        s2_valid_next     = s2_load ? s1_valid_reg : s2_valid_reg;
        result_valid_next = out_free ? (s2_valid_reg && emit) : result_valid_reg;

        // magnitude of the most negative value wraps back to itself, read as unsigned
        mag_x = s1_reg.pos_x[lpsf_pkg::CoordWidth-1] ? (~s1_reg.pos_x + 32'd1) : s1_reg.pos_x;
        mag_y = s1_reg.pos_y[lpsf_pkg::CoordWidth-1] ? (~s1_reg.pos_y + 32'd1) : s1_reg.pos_y;

        s2_next.pt   = s1_reg;
        s2_next.sq_x = mag_x * mag_x;
        s2_next.sq_y = mag_y * mag_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_line_count  <= lpsf_pkg::SCAN_LINE_COUNT_RESET;
            cfg_reg.decimation_ratio <= lpsf_pkg::DECIMATION_RATIO_RESET;
            cfg_reg.blind_radius_sq  <= lpsf_pkg::BLIND_RADIUS_SQ_RESET;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (point_accept)
        begin
            s1_reg <= point_data;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (out_free && s2_valid_reg && emit)
        begin
            result_reg.out_x         <= s2_reg.pt.pos_x;
            result_reg.out_y         <= s2_reg.pt.pos_y;
            result_reg.out_z         <= s2_reg.pt.pos_z;
            result_reg.out_intensity <= s2_reg.pt.reflectivity;
            result_reg.out_time_ns   <= s2_reg.pt.time_offset_ns;
        end
    end

    lpsf_gate u_gate (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (s2_valid_reg && out_free),
        .item  (s2_reg),
        .emit  (emit)
    );

    assign point_stall  = !s1_load;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // a held result blocks the decision stage
    `LPSF_ASSERT_NEXT(a_result_held_blocks, clk, rst_n, result_valid_reg && result_stall && s2_valid_reg, s2_valid_reg && $stable(s2_reg))
    // a new result beat always comes from a point in the decision stage
    `LPSF_ASSERT_NEXT(a_result_has_source, clk, rst_n, out_free && !s2_valid_reg, !result_valid_reg)
    // a full pipeline with a held result takes no new point
    `LPSF_ASSERT_IMPLY(a_full_stalls_input, clk, rst_n, s1_valid_reg && s2_valid_reg && result_valid_reg && result_stall, point_stall)

endmodule

>>> sv/lpsf_gate.sv
// qualification, decimation, duplicate and blind-zone decision with point history
`include "lidar_point_stream_filter_assert.svh"

module lpsf_gate (
    input  logic            clk,
    input  logic            rst_n,
    input  lpsf_pkg::cfg_t   cfg,
    input  logic            step,
    input  lpsf_pkg::stage_t item,
    output logic            emit
);

    logic signed [lpsf_pkg::CoordWidth-1:0] last_x_reg, last_x_next, last_x_cur;
    logic signed [lpsf_pkg::CoordWidth-1:0] last_y_reg, last_y_next, last_y_cur;
    logic signed [lpsf_pkg::CoordWidth-1:0] last_z_reg, last_z_next, last_z_cur;
    logic [7:0] phase_reg, phase_next, phase_cur;
    logic [7:0] ratio_eff;
    logic [8:0] phase_inc;
    logic [7:0] echo;
    logic       qual;
    logic       keep;
    logic       differs;
    logic       far;
    logic [lpsf_pkg::SquareWidth-1:0] radius_sq;

    always_comb
    begin
        phase_cur  = item.pt.frame_start ? 8'd0 : phase_reg;
        last_x_cur = item.pt.frame_start ? '0 : last_x_reg;
        last_y_cur = item.pt.frame_start ? '0 : last_y_reg;
        last_z_cur = item.pt.frame_start ? '0 : last_z_reg;

        ratio_eff = (cfg.decimation_ratio == 8'd0) ? 8'd1 : cfg.decimation_ratio;
        echo      = item.pt.tag_bits & lpsf_pkg::ECHO_MASK;
        qual      = (item.pt.scan_line < cfg.scan_line_count) &&
                    (echo == lpsf_pkg::ECHO_FIRST || echo == lpsf_pkg::ECHO_SECOND);
        keep      = (phase_cur == 8'd0);
        phase_inc = {1'b0, phase_cur} + 9'd1;

        differs = (item.pt.pos_x != last_x_cur) ||
                  (item.pt.pos_y != last_y_cur) ||
                  (item.pt.pos_z != last_z_cur);
        radius_sq = {{(lpsf_pkg::SquareWidth - lpsf_pkg::CfgWidth){1'b0}},
                     cfg.blind_radius_sq};
        far  = (item.sq_x + item.sq_y) > radius_sq;
        emit = qual && keep && differs && far;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        last_z_next = last_z_reg;
        if (step)
        begin
            phase_next = phase_cur;
            if (qual)
            begin
                phase_next = (phase_inc >= {1'b0, ratio_eff}) ? 8'd0 : phase_inc[7:0];
            end
            last_x_next = emit ? item.pt.pos_x : last_x_cur;
            last_y_next = emit ? item.pt.pos_y : last_y_cur;
            last_z_next = emit ? item.pt.pos_z : last_z_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            last_x_reg <= '0;
            last_y_reg <= '0;
            last_z_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            last_z_reg <= last_z_next;
        end
    end

    // an emitted point becomes the history
    `LPSF_ASSERT_NEXT(a_history_follows_emit, clk, rst_n, step && emit, last_x_reg == $past(item.pt.pos_x) && last_y_reg == $past(item.pt.pos_y) && last_z_reg == $past(item.pt.pos_z))
    // frame start with nothing emitted leaves an empty history
    `LPSF_ASSERT_NEXT(a_frame_clears_history, clk, rst_n, step && item.pt.frame_start && !emit, last_x_reg == '0 && last_y_reg == '0 && last_z_reg == '0)
    // rejected points in a running frame leave the decimation phase and the x and z history alone
    `LPSF_ASSERT_NEXT(a_reject_holds_state, clk, rst_n, step && !qual && !item.pt.frame_start, $stable(phase_reg) && $stable(last_x_reg) && $stable(last_z_reg))

endmodule

>>> sim/lpsf_result_checker.sv
`timescale 1ns / 1ps
// result checker for the lidar point stream filter: tracks registers, predicts beats, compares
module lpsf_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             point_valid,
    input  logic                             point_stall,
    input  lpsf_pkg::point_in_t              point_data,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  lpsf_pkg::point_out_t             result_data,
    input  logic                             cfg_wr_en,
    input  logic [lpsf_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [lpsf_pkg::CfgWidth-1:0]    cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               points_seen,
    output int                               results_seen
);

    lpsf_pkg::cfg_t                         filter_cfg;
    logic signed [lpsf_pkg::CoordWidth-1:0] last_x;
    logic signed [lpsf_pkg::CoordWidth-1:0] last_y;
    logic signed [lpsf_pkg::CoordWidth-1:0] last_z;
    logic [7:0]                             decim_phase;
    lpsf_pkg::point_out_t                   expected_points[$];

    function automatic logic [lpsf_pkg::SquareWidth-1:0] coord_square(
        input logic signed [lpsf_pkg::CoordWidth-1:0] v);
        longint wide;
        wide = v;
        return wide * wide;
    endfunction

    // advances the history and decimation phase; returns 1 when the point is emitted
    function automatic bit filter_point(input lpsf_pkg::point_in_t p,
                                        output lpsf_pkg::point_out_t r);
        logic [7:0]                     ratio;
        logic [8:0]                     next_phase;
        logic [lpsf_pkg::SquareWidth:0] radius_sq;
        logic [7:0]                     echo;
        bit                             keep;
        r = '0;
        ratio = (filter_cfg.decimation_ratio == 8'd0) ? 8'd1 : filter_cfg.decimation_ratio;
        echo = p.tag_bits & lpsf_pkg::ECHO_MASK;
        if (p.frame_start)
        begin
            last_x = '0;
            last_y = '0;
            last_z = '0;
            decim_phase = '0;
        end
        if (p.scan_line >= filter_cfg.scan_line_count)
            return 0;
        if (echo != lpsf_pkg::ECHO_FIRST && echo != lpsf_pkg::ECHO_SECOND)
            return 0;
        keep = (decim_phase == 8'd0);
        next_phase = {1'b0, decim_phase} + 9'd1;
        decim_phase = (next_phase >= {1'b0, ratio}) ? 8'd0 : next_phase[7:0];
        if (!keep)
            return 0;
        if (p.pos_x == last_x && p.pos_y == last_y && p.pos_z == last_z)
            return 0;
        radius_sq = coord_square(p.pos_x) + coord_square(p.pos_y);
        if (radius_sq <= filter_cfg.blind_radius_sq)
            return 0;
        last_x = p.pos_x;
        last_y = p.pos_y;
        last_z = p.pos_z;
        r.out_x = p.pos_x;
        r.out_y = p.pos_y;
        r.out_z = p.pos_z;
        r.out_intensity = p.reflectivity;
        r.out_time_ns = p.time_offset_ns;
        return 1;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %h got %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        lpsf_pkg::point_out_t want;
        lpsf_pkg::point_out_t made;
        if (!rst_n)
        begin
            filter_cfg.scan_line_count = lpsf_pkg::SCAN_LINE_COUNT_RESET;
            filter_cfg.decimation_ratio = lpsf_pkg::DECIMATION_RATIO_RESET;
            filter_cfg.blind_radius_sq = lpsf_pkg::BLIND_RADIUS_SQ_RESET;
            last_x = '0;
            last_y = '0;
            last_z = '0;
            decim_phase = '0;
            expected_points.delete();
            fail_count = 0;
            points_seen = 0;
            results_seen = 0;
        end
        else
        begin
            // result side first so a beat never meets the expectation of its own edge
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_points.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, expected none got %h",
                             $time, result_data);
                end
                else
                begin
                    want = expected_points.pop_front();
                    check_field("out_x", want.out_x, result_data.out_x);
                    check_field("out_y", want.out_y, result_data.out_y);
                    check_field("out_z", want.out_z, result_data.out_z);
                    check_field("out_intensity", {24'd0, want.out_intensity},
                                {24'd0, result_data.out_intensity});
                    check_field("out_time_ns", want.out_time_ns, result_data.out_time_ns);
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lpsf_pkg::REG_SCAN_LINE_COUNT:
                        filter_cfg.scan_line_count = cfg_data[7:0];
                    lpsf_pkg::REG_DECIMATION_RATIO:
                        filter_cfg.decimation_ratio = cfg_data[7:0];
                    lpsf_pkg::REG_BLIND_RADIUS_SQ:
                        filter_cfg.blind_radius_sq = cfg_data;
                    default: ;
                endcase
            end
            if (point_valid && !point_stall)
            begin
                points_seen++;
                if (filter_point(point_data, made))
                    expected_points = {expected_points, made};
            end
        end
        pending = expected_points.size();
    end

endmodule

>>> sim/tb_lidar_point_stream_filter.sv
`timescale 1ns / 1ps
// testbench top for the lidar point stream filter: stimulus, register settings and verdict
module tb_lidar_point_stream_filter;

    localparam int HalfPeriod  = 6;
    localparam int DrainCycles = 8;
    localparam int QuietLimit  = 1000;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             point_valid = 1'b0;
    logic                             point_stall;
    lpsf_pkg::point_in_t              point_data = '0;
    logic                             result_valid;
    logic                             result_stall = 1'b0;
    lpsf_pkg::point_out_t             result_data;
    logic                             cfg_wr_en = 1'b0;
    logic [lpsf_pkg::CfgIdxWidth-1:0] cfg_index = '0;
    logic [lpsf_pkg::CfgWidth-1:0]    cfg_data = '0;

    int                  fail_count;
    int                  pending;
    int                  points_seen;
    int                  results_seen;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  settings_used = 0;
    int                  quiet_cycles = 0;
    logic [7:0]          cur_scan = lpsf_pkg::SCAN_LINE_COUNT_RESET;
    lpsf_pkg::point_in_t last_sent = '0;

    always #(HalfPeriod) clk = ~clk;

    lidar_point_stream_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_data   (point_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lpsf_result_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_data   (point_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .points_seen  (points_seen),
        .results_seen (results_seen)
    );

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (point_valid && !point_stall) ||
            (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("tb_lidar_point_stream_filter: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic lpsf_pkg::point_in_t mk_point(input logic fs, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z,
                                           input logic [7:0] refl, input logic [7:0] tag,
                                           input logic [7:0] line, input logic [31:0] t);
        lpsf_pkg::point_in_t p;
        p.frame_start = fs;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        p.reflectivity = refl;
        p.tag_bits = tag;
        p.scan_line = line;
        p.time_offset_ns = t;
        return p;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            6:          return 32'($urandom_range(0, 8)) - 32'd4;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0001_0000;
                    default: return 32'hffff_0000;
                endcase
            end
            default:    return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        endcase
    endfunction

    // mostly qualified points; some repeat the previous coordinates to hit the duplicate test
    function automatic lpsf_pkg::point_in_t random_point(input lpsf_pkg::point_in_t prev,
                                                         input logic [7:0] scan_count);
        lpsf_pkg::point_in_t p;
        p.frame_start = ($urandom_range(0, 99) < 3);
        p.pos_x = random_coord();
        p.pos_y = random_coord();
        p.pos_z = random_coord();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                p.pos_x = prev.pos_x;
                p.pos_y = prev.pos_y;
                p.pos_z = prev.pos_z;
            end
            2:
            begin
                p.pos_x = prev.pos_x;
                p.pos_y = prev.pos_y;
            end
            default: ;
        endcase
        p.reflectivity = 8'($urandom);
        p.tag_bits = 8'($urandom);
        if ($urandom_range(0, 99) < 85)
            p.tag_bits[5:4] = {1'b0, 1'($urandom_range(0, 1))};
        p.scan_line = 8'($urandom);
        if (scan_count != 8'd0 && $urandom_range(0, 99) < 85)
            p.scan_line = 8'($urandom_range(0, 32'(scan_count) - 1));
        p.time_offset_ns = $urandom;
        return p;
    endfunction

    // called and returns at a falling edge; valid stays high for a following beat
    task automatic send_point(input lpsf_pkg::point_in_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(negedge clk);
        end
        point_valid <= 1'b1;
        point_data <= p;
        last_sent = p;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        int calm;
        calm = 0;
        point_valid <= 1'b0;
        while (calm < DrainCycles)
        begin
            @(negedge clk);
            calm = (pending == 0) ? calm + 1 : 0;
        end
    endtask

    task automatic change_settings(input logic [7:0] scan, input logic [7:0] ratio,
                                   input logic [lpsf_pkg::CfgWidth-1:0] blind);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= lpsf_pkg::REG_SCAN_LINE_COUNT;
        cfg_data <= {32'd0, scan};
        @(negedge clk);
        cfg_index <= lpsf_pkg::REG_DECIMATION_RATIO;
        cfg_data <= {32'd0, ratio};
        @(negedge clk);
        cfg_index <= lpsf_pkg::REG_BLIND_RADIUS_SQ;
        cfg_data <= blind;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_scan = scan;
        settings_used++;
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_point(random_point(last_sent, cur_scan));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: qualification, duplicates, extremes, blind zone, frame restart
        send_point(mk_point(1'b1, 32'h0001_0000, 32'd0, 32'd0, 8'h00, 8'h00, 8'd0, 32'd0));
        send_point(mk_point(1'b0, 32'h0001_0000, 32'd0, 32'd0, 8'h11, 8'h00, 8'd1, 32'd100));
        send_point(mk_point(1'b0, 32'h0001_0000, 32'd0, 32'd1, 8'h22, 8'hcf, 8'd5, 32'd200));
        send_point(mk_point(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 8'hff, 8'h10,
                            8'd5, 32'hffff_ffff));
        send_point(mk_point(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 8'h80, 8'hdf,
                            8'd2, 32'h8000_0000));
        send_point(mk_point(1'b0, 32'h0100_0000, 32'd0, 32'd0, 8'h01, 8'h20, 8'd0, 32'd1));
        send_point(mk_point(1'b0, 32'h0200_0000, 32'd0, 32'd0, 8'h02, 8'h30, 8'd0, 32'd2));
        send_point(mk_point(1'b0, 32'h0300_0000, 32'd0, 32'd0, 8'h03, 8'hff, 8'd0, 32'd3));
        send_point(mk_point(1'b0, 32'h0400_0000, 32'd0, 32'd0, 8'h04, 8'h00, 8'd6, 32'd4));
        send_point(mk_point(1'b0, 32'h0500_0000, 32'd0, 32'd0, 8'h05, 8'h00, 8'd255, 32'd5));
        send_point(mk_point(1'b0, 32'd0, 32'd0, 32'd5, 8'h06, 8'h00, 8'd0, 32'd6));
        send_point(mk_point(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 8'h07, 8'h00,
                            8'd0, 32'd7));
        send_point(mk_point(1'b1, 32'd0, 32'd0, 32'd0, 8'h08, 8'h00, 8'd0, 32'd8));
        send_point(mk_point(1'b0, 32'hffff_0000, 32'd0, 32'd0, 8'h09, 8'h10, 8'd3, 32'd9));

        // blind threshold reached exactly, then the ratio lowered below the running phase
        change_settings(8'd6, 8'd5, 40'h01_0000_0000);
        send_point(mk_point(1'b0, 32'h0001_0000, 32'd0, 32'd7, 8'h10, 8'h00, 8'd0, 32'd10));
        send_point(mk_point(1'b0, 32'h0001_0001, 32'd0, 32'd0, 8'h11, 8'h00, 8'd0, 32'd11));
        send_point(mk_point(1'b0, 32'h0002_0000, 32'd0, 32'd0, 8'h12, 8'h00, 8'd0, 32'd12));
        change_settings(8'd6, 8'd2, 40'h01_0000_0000);
        send_point(mk_point(1'b0, 32'h0003_0000, 32'd0, 32'd0, 8'h13, 8'h00, 8'd0, 32'd13));
        send_point(mk_point(1'b0, 32'h0001_0001, 32'd0, 32'd0, 8'h14, 8'h00, 8'd0, 32'd14));
        // ratio zero keeps every qualified point
        change_settings(8'd6, 8'd0, 40'h01_0000_0000);
        send_point(mk_point(1'b0, 32'h0004_0000, 32'd0, 32'd0, 8'h15, 8'h00, 8'd0, 32'd15));
        send_point(mk_point(1'b0, 32'h0005_0000, 32'd0, 32'd0, 8'h16, 8'h10, 8'd0, 32'd16));

        send_idle_pct = 0;
        stall_pct = 0;
        change_settings(8'd6, 8'd1, lpsf_pkg::BLIND_RADIUS_SQ_RESET);
        run_random(200);

        send_idle_pct = 56;
        stall_pct = 0;
        change_settings(8'd255, 8'd3, 40'd0);
        run_random(200);

        send_idle_pct = 0;
        stall_pct = 56;
        change_settings(8'd16, 8'd0, 40'hff_ffff_ffff);
        run_random(200);

        send_idle_pct = 18;
        stall_pct = 18;
        change_settings(8'd64, 8'd2, lpsf_pkg::BLIND_RADIUS_SQ_RESET);
        run_random(200);

        change_settings(8'd0, 8'd1, 40'd0);
        run_random(60);

        send_idle_pct = 0;
        stall_pct = 0;
        change_settings(8'd128, 8'd255, 40'd1000);
        run_random(90);

        send_idle_pct = 18;
        stall_pct = 18;
        change_settings(8'd200, 8'd4, 40'h01_0000_0000);
        run_random(200);

        send_idle_pct = 56;
        stall_pct = 56;
        change_settings(8'd32, 8'd1, 40'h10_0000_0000);
        run_random(200);

        wait_idle();
        $display("run covered %0d point beats and %0d result beats over %0d register settings",
                 points_seen, results_seen, settings_used);
        $display("with no idling, sender gaps, receiver stalls and both mixed");
        if (fail_count == 0 && pending == 0)
            $display("tb_lidar_point_stream_filter: clean");
        else
            $display("tb_lidar_point_stream_filter: errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/lpsf_pkg.sv
sv/lpsf_gate.sv
sv/lidar_point_stream_filter.sv
sim/lpsf_result_checker.sv
sim/tb_lidar_point_stream_filter.sv
